@@ rtl/nms_pkg.sv @@
// nms_pkg: shared types, constants and register codes for the neighbour mean smoother.
// Used by every file under rtl; depends on nothing.
`timescale 1ns / 1ps

package nms_pkg;

	// Default capacity of the block
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Pixel and neighbourhood geometry
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int NUM_NB   = 8;
	localparam int PIX_W    = CHAN_W * NUM_CHAN;

	// Neighbour positions around the centre
	localparam int NB_TL = 0;
	localparam int NB_T  = 1;
	localparam int NB_TR = 2;
	localparam int NB_L  = 3;
	localparam int NB_R  = 4;
	localparam int NB_BL = 5;
	localparam int NB_B  = 6;
	localparam int NB_BR = 7;

	// Configuration registers
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_WIDTH    = 2;
	localparam int MIN_HEIGHT   = 1;

	// Neighbour sum and reciprocal division (exact for sums below 2048)
	localparam int SUM_W       = 11;
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 13;
	localparam logic [RECIP_W-1:0] RECIP_3 = 12'd2731;
	localparam logic [RECIP_W-1:0] RECIP_5 = 12'd1639;

	typedef logic [CHAN_W-1:0] chan_t;

	// red in the lowest byte, matching the stream packing
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	// One line buffer word: the pixel one row up and the one two rows up
	typedef struct packed {
		pixel_t row1;
		pixel_t row2;
	} line_entry_t;

	typedef logic [NUM_NB-1:0][CHAN_W-1:0] nb_vec_t;

	typedef enum logic {
		OP_PIXEL,
		OP_FLUSH
	} op_t;

	typedef enum logic [2:0] {
		DIV_1,
		DIV_2,
		DIV_3,
		DIV_5,
		DIV_8
	} div_t;

	typedef struct packed {
		logic load;
		div_t div;
	} lane_ctrl_t;

	typedef struct packed {
		logic   last;
		pixel_t pix;
	} result_t;

endpackage

@@ rtl/nms_line_buf.sv @@
// nms_line_buf: single-port-write, registered-read line buffer holding the two
// previous rows of each column. Depends on nms_pkg.
`timescale 1ns / 1ps

module nms_line_buf #(
	parameter int DEPTH = nms_pkg::DEF_MAX_WIDTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output nms_pkg::line_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  nms_pkg::line_entry_t wr_data
);

	nms_pkg::line_entry_t mem_q [DEPTH];
	nms_pkg::line_entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/nms_lane.sv @@
// nms_lane: one colour channel lane: masked sum of the eight neighbours, then
// division by the neighbour count via shift or reciprocal multiply. Depends on nms_pkg.
`timescale 1ns / 1ps

module nms_lane (
	input  logic                clk,
	input  nms_pkg::lane_ctrl_t ctrl,
	input  nms_pkg::nb_vec_t    nb,
	input  logic [nms_pkg::NUM_NB-1:0] nb_mask,
	output nms_pkg::chan_t      mean
);

	localparam int PROD_W = nms_pkg::SUM_W + nms_pkg::RECIP_W;

	logic [nms_pkg::SUM_W-1:0]   sum;
	logic [nms_pkg::SUM_W-1:0]   sum_s3;
	nms_pkg::div_t               div_s3;
	logic [nms_pkg::RECIP_W-1:0] recip;
	logic [PROD_W-1:0]           prod;

	// adder tree over the neighbours that lie inside the frame
	always_comb begin
		sum = '0;
		for (int i = 0; i < nms_pkg::NUM_NB; i++) begin
			if (nb_mask[i]) begin
				sum = sum + nms_pkg::SUM_W'(nb[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sum_s3 <= sum;
			div_s3 <= ctrl.div;
		end
	end

	// divide by 3 or 5 through the reciprocal
	assign recip = (div_s3 == nms_pkg::DIV_3) ? nms_pkg::RECIP_3 : nms_pkg::RECIP_5;
	assign prod  = PROD_W'(sum_s3) * PROD_W'(recip);

	always_comb begin
		unique case (div_s3)
			nms_pkg::DIV_1: mean = sum_s3[nms_pkg::CHAN_W-1:0];
			nms_pkg::DIV_2: mean = sum_s3[1 +: nms_pkg::CHAN_W];
			nms_pkg::DIV_8: mean = sum_s3[3 +: nms_pkg::CHAN_W];
			nms_pkg::DIV_3,
			nms_pkg::DIV_5: mean = prod[nms_pkg::RECIP_SHIFT +: nms_pkg::CHAN_W];
			default:        mean = sum_s3[nms_pkg::CHAN_W-1:0];
		endcase
	end

endmodule

@@ rtl/neighbour_mean_smoother.sv @@
// The result for pixel k is formed from item k+W+1 via the line buffer, 3x3 window and lane registers.
// Throughput: one item per clock; the line buffer is read and written once per item.
// The input stalls only while two results wait unclaimed in the output buffer.
// Reset (arst_n low): width 640, height 480, frame counters and pipeline cleared;
// the line buffer keeps its contents and needs no clearing pass.
// Top level; depends on nms_pkg, nms_line_buf and nms_lane.
`timescale 1ns / 1ps

module neighbour_mean_smoother #(
	parameter int MAX_WIDTH  = nms_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = nms_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: [7:0] red_in, [15:8] green_in, [23:16] blue_in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nms_pkg::PIX_W-1:0]       s_tdata,
	// s_tuser: [0] op
	input  logic                            s_tuser,
	// m_tdata: [7:0] red_out, [15:8] green_out, [23:16] blue_out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nms_pkg::PIX_W-1:0]       m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_wr_en,
	input  logic [nms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [nms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int NB_CNT_W = 4;
	localparam int BUF_DEPTH = 2;
	localparam int BUF_CNT_W = 2;

	localparam logic [WW-1:0] RST_W =
		WW'((nms_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : nms_pkg::RESET_WIDTH);
	localparam logic [HW-1:0] RST_H =
		HW'((nms_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : nms_pkg::RESET_HEIGHT);

	typedef struct packed {
		logic emit;
		logic up;
		logic down;
		logic left;
		logic right;
		logic done;
	} pos_ctl_t;

	// effective frame size
	logic [WW-1:0] eff_w_q, sat_w, w_m1;
	logic [HW-1:0] eff_h_q, sat_h, h_m1;
	logic [nms_pkg::IMG_W_BITS-1:0] raw_w;
	logic [nms_pkg::IMG_H_BITS-1:0] raw_h;

	// frame position
	logic [AW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q;
	logic [HW-1:0] out_row_q;

	logic           en, accept, is_pixel, in_last_col;
	nms_pkg::pixel_t cur;
	pos_ctl_t       pos;

	// stage 1
	logic                 v_s1_q;
	nms_pkg::pixel_t      cur_s1;
	logic [AW-1:0]        col_s1;
	pos_ctl_t             ctl_s1;
	nms_pkg::line_entry_t rd_s1;
	nms_pkg::line_entry_t wr_entry;

	// stage 2: 3x3 window
	logic            v_s2_q;
	pos_ctl_t        ctl_s2;
	nms_pkg::pixel_t top_s2 [3];
	nms_pkg::pixel_t mid_s2 [3];
	nms_pkg::pixel_t bot_s2 [3];
	nms_pkg::pixel_t nb_pix [nms_pkg::NUM_NB];
	logic [nms_pkg::NUM_NB-1:0] nb_mask;
	logic [NB_CNT_W-1:0]        nb_cnt;
	nms_pkg::div_t              div_sel;
	nms_pkg::lane_ctrl_t        lane_ctrl;
	nms_pkg::nb_vec_t           lane_nb   [nms_pkg::NUM_CHAN];
	nms_pkg::chan_t             lane_mean [nms_pkg::NUM_CHAN];

	// stage 3
	logic v_s3_q;
	logic done_s3;

	// output buffer
	nms_pkg::result_t     out_buf_q [BUF_DEPTH];
	nms_pkg::result_t     res;
	logic                 wr_ptr_q, rd_ptr_q;
	logic [BUF_CNT_W-1:0] cnt_q;
	logic                 push, pop;

	// saturate written width and height to the supported range
	always_comb begin
		raw_w = cfg_wdata[nms_pkg::IMG_W_BITS-1:0];
		raw_h = cfg_wdata[nms_pkg::IMG_H_BITS-1:0];
		if (32'(raw_w) < nms_pkg::MIN_WIDTH) begin
			sat_w = WW'(nms_pkg::MIN_WIDTH);
		end else if (32'(raw_w) > MAX_WIDTH) begin
			sat_w = WW'(MAX_WIDTH);
		end else begin
			sat_w = WW'(raw_w);
		end
		if (32'(raw_h) < nms_pkg::MIN_HEIGHT) begin
			sat_h = HW'(nms_pkg::MIN_HEIGHT);
		end else if (32'(raw_h) > MAX_HEIGHT) begin
			sat_h = HW'(MAX_HEIGHT);
		end else begin
			sat_h = HW'(raw_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= RST_W;
			eff_h_q <= RST_H;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				nms_pkg::REG_IMAGE_WIDTH:  eff_w_q <= sat_w;
				nms_pkg::REG_IMAGE_HEIGHT: eff_h_q <= sat_h;
			endcase
		end
	end

	// position decode for the incoming transaction
	assign w_m1 = eff_w_q - 1'b1;
	assign h_m1 = eff_h_q - 1'b1;

	assign s_tready = en;
	assign accept   = s_tvalid && en;

	always_comb begin
		is_pixel    = in_row_q < RW'(eff_h_q);
		in_last_col = in_col_q == AW'(w_m1);
		cur         = '0;
		if (is_pixel && nms_pkg::op_t'(s_tuser) == nms_pkg::OP_PIXEL) begin
			cur = nms_pkg::pixel_t'(s_tdata);
		end
		pos.emit  = (in_row_q > RW'(1)) || (in_row_q == RW'(1) && in_col_q != '0);
		pos.up    = out_row_q != '0;
		pos.down  = out_row_q < h_m1;
		pos.left  = out_col_q != '0;
		pos.right = out_col_q < AW'(w_m1);
		pos.done  = pos.emit && !pos.down && !pos.right;
	end

	// frame counters; a config write or the final result restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en || (accept && pos.done)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (in_last_col) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
			if (pos.emit) begin
				if (!pos.right) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else if (en) begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q && ctl_s2.emit;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= cur;
			col_s1 <= in_col_q;
			ctl_s1 <= pos;
		end
	end

	// line buffer: read the column on accept, write it back in the cycle after
	assign wr_entry.row1 = cur_s1;
	assign wr_entry.row2 = rd_s1.row1;

	nms_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (rd_s1),
		.wr_en   (v_s1_q),
		.wr_addr (col_s1),
		.wr_data (wr_entry)
	);

	// stage 2: shift the 3x3 window by one column
	always_ff @(posedge clk) begin
		if (en && v_s1_q) begin
			bot_s2[0] <= cur_s1;
			bot_s2[1] <= bot_s2[0];
			bot_s2[2] <= bot_s2[1];
			mid_s2[0] <= rd_s1.row1;
			mid_s2[1] <= mid_s2[0];
			mid_s2[2] <= mid_s2[1];
			top_s2[0] <= rd_s1.row2;
			top_s2[1] <= top_s2[0];
			top_s2[2] <= top_s2[1];
			ctl_s2    <= ctl_s1;
		end
	end

	// neighbours of the window centre and which of them lie in the frame
	always_comb begin
		nb_pix[nms_pkg::NB_TL] = top_s2[2];
		nb_pix[nms_pkg::NB_T]  = top_s2[1];
		nb_pix[nms_pkg::NB_TR] = top_s2[0];
		nb_pix[nms_pkg::NB_L]  = mid_s2[2];
		nb_pix[nms_pkg::NB_R]  = mid_s2[0];
		nb_pix[nms_pkg::NB_BL] = bot_s2[2];
		nb_pix[nms_pkg::NB_B]  = bot_s2[1];
		nb_pix[nms_pkg::NB_BR] = bot_s2[0];

		nb_mask[nms_pkg::NB_TL] = ctl_s2.up && ctl_s2.left;
		nb_mask[nms_pkg::NB_T]  = ctl_s2.up;
		nb_mask[nms_pkg::NB_TR] = ctl_s2.up && ctl_s2.right;
		nb_mask[nms_pkg::NB_L]  = ctl_s2.left;
		nb_mask[nms_pkg::NB_R]  = ctl_s2.right;
		nb_mask[nms_pkg::NB_BL] = ctl_s2.down && ctl_s2.left;
		nb_mask[nms_pkg::NB_B]  = ctl_s2.down;
		nb_mask[nms_pkg::NB_BR] = ctl_s2.down && ctl_s2.right;

		for (int c = 0; c < nms_pkg::NUM_CHAN; c++) begin
			for (int i = 0; i < nms_pkg::NUM_NB; i++) begin
				lane_nb[c][i] = nb_pix[i][c*nms_pkg::CHAN_W +: nms_pkg::CHAN_W];
			end
		end
	end

	// divisor from the neighbour count; corners of a one-row frame have a single one
	always_comb begin
		nb_cnt = NB_CNT_W'($countones(nb_mask));
		unique case (nb_cnt)
			4'd1:    div_sel = nms_pkg::DIV_1;
			4'd2:    div_sel = nms_pkg::DIV_2;
			4'd3:    div_sel = nms_pkg::DIV_3;
			4'd5:    div_sel = nms_pkg::DIV_5;
			4'd8:    div_sel = nms_pkg::DIV_8;
			default: div_sel = nms_pkg::DIV_1;
		endcase
	end

	assign lane_ctrl.load = en && v_s2_q && ctl_s2.emit;
	assign lane_ctrl.div  = div_sel;

	always_ff @(posedge clk) begin
		if (lane_ctrl.load) begin
			done_s3 <= ctl_s2.done;
		end
	end

	// one lane per colour channel
	for (genvar c = 0; c < nms_pkg::NUM_CHAN; c++) begin : g_lane
		nms_lane u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.nb      (lane_nb[c]),
			.nb_mask (nb_mask),
			.mean    (lane_mean[c])
		);
	end

	// merge the lane results into one transaction
	assign res.last      = done_s3;
	assign res.pix.red   = lane_mean[0];
	assign res.pix.green = lane_mean[1];
	assign res.pix.blue  = lane_mean[2];

	// two-entry output buffer; the pipeline holds only when it is full
	assign en   = cnt_q != BUF_CNT_W'(BUF_DEPTH);
	assign push = en && v_s3_q;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			out_buf_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = out_buf_q[rd_ptr_q].pix;
	assign m_tlast  = out_buf_q[rd_ptr_q].last;

endmodule

@@ rtl/nms_checker.sv @@
// nms_port_checks: port-level assertions for the neighbour mean smoother, bound to the top level.
// Depends on nms_pkg and neighbour_mean_smoother.
`timescale 1ns / 1ps

module nms_port_checks (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [nms_pkg::PIX_W-1:0] m_tdata,
	input logic                      m_tlast
);

	logic [31:0] in_cnt_q;
	logic [31:0] out_cnt_q;

	// running tally of transactions on each side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				in_cnt_q <= in_cnt_q + 1'b1;
			end
			if (m_tvalid && m_tready) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end
		end
	end

	// a waiting result holds its value until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// with nothing waiting at the output the input never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// every result comes from an earlier input transaction
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> out_cnt_q < in_cnt_q)
		else $error("more results than input transactions");

endmodule

bind neighbour_mean_smoother nms_port_checks u_nms_port_checks (.*);
